// ===== rtl/integer_to_radix_ascii_macros.svh =====
// assertion macros shared by the integer to radix ascii rtl
`ifndef INTEGER_TO_RADIX_ASCII_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ITRA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define ITRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/itra_pkg.sv =====
// package with widths, microcode types and character helpers
`timescale 1ns / 1ps

package itra_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int VALUE_W            = 32;
    localparam int RADIX_W            = 5;
    localparam int CHAR_W             = 8;
    localparam int DIGIT_W            = 4;
    localparam int CHUNK_BITS         = 8;
    localparam int STEP_W             = 3;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_MINUS   = 8'h2d;

    // microcode program addresses
    localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DIV   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_STORE = 3'd2;
    localparam logic [STEP_W-1:0] STEP_SIGN  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_READ  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd5;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_DIV,
        ACT_STORE,
        ACT_SIGN,
        ACT_READ,
        ACT_EMIT
    } act_t;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_SLOT,
        HOLD_SLOT_NEG
    } hold_t;

    typedef enum logic [1:0] {
        JMP_NEVER,
        JMP_CHUNK_MORE,
        JMP_DIGIT_MORE,
        JMP_CHAR_MORE
    } jump_t;

    typedef struct packed {
        act_t              act;
        hold_t             hold;
        jump_t             jmp;
        logic [STEP_W-1:0] jmp_to;
        logic [STEP_W-1:0] seq_to;
    } ctrl_t;

    // control store: one word per program step
    function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{act: ACT_LOAD, hold: HOLD_IN, jmp: JMP_NEVER,
              jmp_to: STEP_IDLE, seq_to: STEP_DIV};
        case (step)
            STEP_IDLE:  w = '{act: ACT_LOAD, hold: HOLD_IN, jmp: JMP_NEVER,
                              jmp_to: STEP_IDLE, seq_to: STEP_DIV};
            STEP_DIV:   w = '{act: ACT_DIV, hold: HOLD_NONE, jmp: JMP_CHUNK_MORE,
                              jmp_to: STEP_DIV, seq_to: STEP_STORE};
            STEP_STORE: w = '{act: ACT_STORE, hold: HOLD_NONE, jmp: JMP_DIGIT_MORE,
                              jmp_to: STEP_DIV, seq_to: STEP_SIGN};
            STEP_SIGN:  w = '{act: ACT_SIGN, hold: HOLD_SLOT_NEG, jmp: JMP_NEVER,
                              jmp_to: STEP_IDLE, seq_to: STEP_READ};
            STEP_READ:  w = '{act: ACT_READ, hold: HOLD_NONE, jmp: JMP_NEVER,
                              jmp_to: STEP_IDLE, seq_to: STEP_EMIT};
            STEP_EMIT:  w = '{act: ACT_EMIT, hold: HOLD_SLOT, jmp: JMP_CHAR_MORE,
                              jmp_to: STEP_READ, seq_to: STEP_IDLE};
            default:    w = '{act: ACT_NONE, hold: HOLD_NONE, jmp: JMP_NEVER,
                              jmp_to: STEP_IDLE, seq_to: STEP_IDLE};
        endcase
        return w;
    endfunction

    // digit value to ascii, upper or lower case letters
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic lower);
        logic [CHAR_W-1:0] ext;
        ext = CHAR_W'(d);
        if (d < 4'd10)
            return ASCII_ZERO + ext;
        else if (lower)
            return ASCII_LOWER_A + ext - 8'd10;
        else
            return ASCII_UPPER_A + ext - 8'd10;
    endfunction

endpackage

// ===== rtl/itra_num_if.sv =====
// channel carrying one number and its conversion options
`timescale 1ns / 1ps

interface itra_num_if;
    import itra_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value_bits;
    logic [RADIX_W-1:0] radix;
    logic               unsigned_mode;
    logic               lower_case;

    modport source (output valid, value_bits, radix, unsigned_mode, lower_case,
                    input ready);
    modport sink   (input valid, value_bits, radix, unsigned_mode, lower_case,
                    output ready);
endinterface

// ===== rtl/itra_char_if.sv =====
// channel carrying one output character
`timescale 1ns / 1ps

interface itra_char_if;
    import itra_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ascii_char;
    logic              last_char;

    modport source (output valid, ascii_char, last_char, input ready);
    modport sink   (input valid, ascii_char, last_char, output ready);
endinterface

// ===== rtl/integer_to_radix_ascii.sv =====
// microcoded integer to radix ascii converter, top level
//
//  channel   dir   payload                                    handshake
//  number    in    value_bits, radix, unsigned_mode, lower_case  valid/ready
//  chars     out   ascii_char, last_char                      valid/ready
//
// one number at a time; ready only while the sequencer sits at its idle step
// each digit is divided out one 8-bit chunk at a time in the shared divide unit
// (8 quotient bits per cycle), stored, and later read back and sent
// output stalls lengthen a conversion
// rst_n clears the sequencer and the output register at once, no clear pass
// a stalled output transaction holds the sequencer at its sign or emit step
`timescale 1ns / 1ps
`include "integer_to_radix_ascii_macros.svh"

module integer_to_radix_ascii #(
    parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    itra_num_if.sink    number,
    itra_char_if.source chars
);
    import itra_pkg::*;

    // quotient register padded to whole 8-bit chunks
    localparam int NCHUNK = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int QW     = NCHUNK * CHUNK_BITS;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int CNTW   = $clog2(VALUE_BITS + 1);
    localparam int AW     = $clog2(VALUE_BITS);

    // sequencer
    logic [STEP_W-1:0] step_reg, step_next;
    ctrl_t             ctl;
    logic              go;
    logic              jump_taken;

    // datapath registers
    logic [QW-1:0]      q_reg, q_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [RADIX_W-1:0] r_reg, r_next;
    logic               neg_reg, neg_next;
    logic               lower_reg, lower_next;
    logic [CW-1:0]      chunk_reg, chunk_next;
    logic [CNTW-1:0]    count_reg, count_next;
    logic [DIGIT_W-1:0] rd_reg;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;
    logic              slot_free;

    // digit store, least significant digit first
    logic [DIGIT_W-1:0] store_mem [VALUE_BITS];
    logic               store_we;
    logic [AW-1:0]      store_waddr;
    logic [AW-1:0]      store_raddr;

    // input decode
    logic [QW-1:0]         v_ext;
    logic [VALUE_BITS-1:0] v_w;
    logic [VALUE_BITS-1:0] mag_w;
    logic                  in_neg;
    logic [RADIX_W-1:0]    r_sat;

    // divide unit: 8 restoring steps on the top chunk
    logic [RADIX_W-1:0]    rem_w;
    logic [RADIX_W-1:0]    trial;
    logic [CHUNK_BITS-1:0] qbits;

    assign ctl       = ucode_rom(step_reg);
    assign slot_free = !out_valid_reg || chars.ready;

    always_comb
    begin
        case (ctl.hold)
            HOLD_NONE:     go = 1'b1;
            HOLD_IN:       go = number.valid;
            HOLD_SLOT:     go = slot_free;
            HOLD_SLOT_NEG: go = slot_free || !neg_reg;
            default:       go = 1'b1;
        endcase
    end

    always_comb
    begin
        case (ctl.jmp)
            JMP_NEVER:      jump_taken = 1'b0;
            JMP_CHUNK_MORE: jump_taken = (chunk_reg != CW'(NCHUNK - 1));
            JMP_DIGIT_MORE: jump_taken = (q_reg != '0)
                                && (CNTW'(count_reg + 1'b1) < CNTW'(VALUE_BITS));
            JMP_CHAR_MORE:  jump_taken = (count_reg != CNTW'(1));
            default:        jump_taken = 1'b0;
        endcase
    end

    always_comb
    begin
        if (!go)
            step_next = step_reg;
        else if (jump_taken)
            step_next = ctl.jmp_to;
        else
            step_next = ctl.seq_to;
    end

    assign number.ready = (ctl.hold == HOLD_IN);

    // input decode: mask to the configured width, negate negative values in signed mode, clamp the radix
    always_comb
    begin
        v_ext  = QW'(number.value_bits);
        v_w    = v_ext[VALUE_BITS-1:0];
        in_neg = !number.unsigned_mode && v_w[VALUE_BITS-1];
        mag_w  = in_neg ? (~v_w + 1'b1) : v_w;
        if (number.radix < RADIX_MIN)
            r_sat = RADIX_MIN;
        else if (number.radix > RADIX_MAX)
            r_sat = RADIX_MAX;
        else
            r_sat = number.radix;
    end

    always_comb
    begin
        rem_w = {1'b0, rem_reg};
        qbits = '0;
        trial = '0;
        for (int i = 0; i < CHUNK_BITS; i++)
        begin
            trial = {rem_w[DIGIT_W-1:0], q_reg[QW-1-i]};
            if (trial >= r_reg)
            begin
                qbits[CHUNK_BITS-1-i] = 1'b1;
                rem_w                 = trial - r_reg;
            end
            else
            begin
                rem_w = trial;
            end
        end
    end

    assign store_waddr = count_reg[AW-1:0];
    assign store_raddr = AW'(count_reg - CNTW'(1));

    // datapath actions of the current control word
    always_comb
    begin
        q_next         = q_reg;
        rem_next       = rem_reg;
        r_next         = r_reg;
        neg_next       = neg_reg;
        lower_next     = lower_reg;
        chunk_next     = chunk_reg;
        count_next     = count_reg;
        store_we       = 1'b0;
        out_valid_next = out_valid_reg && !chars.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (go)
        begin
            case (ctl.act)
                ACT_NONE:
                begin
                end
                ACT_LOAD:
                begin
                    q_next     = QW'(mag_w);
                    rem_next   = '0;
                    r_next     = r_sat;
                    neg_next   = in_neg;
                    lower_next = number.lower_case;
                    chunk_next = '0;
                    count_next = '0;
                end
                ACT_DIV:
                begin
                    q_next     = (q_reg << CHUNK_BITS) | QW'(qbits);
                    rem_next   = rem_w[DIGIT_W-1:0];
                    chunk_next = (chunk_reg == CW'(NCHUNK - 1)) ? '0 : CW'(chunk_reg + 1'b1);
                end
                ACT_STORE:
                begin
                    store_we   = 1'b1;
                    rem_next   = '0;
                    count_next = CNTW'(count_reg + 1'b1);
                end
                ACT_SIGN:
                begin
                    if (neg_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = ASCII_MINUS;
                        out_last_next  = 1'b0;
                    end
                end
                ACT_READ:
                begin
                end
                ACT_EMIT:
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_char(rd_reg, lower_reg);
                    out_last_next  = (count_reg == CNTW'(1));
                    count_next     = CNTW'(count_reg - 1'b1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            q_reg         <= '0;
            rem_reg       <= '0;
            r_reg         <= RADIX_MIN;
            neg_reg       <= 1'b0;
            lower_reg     <= 1'b0;
            chunk_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            q_reg         <= q_next;
            rem_reg       <= rem_next;
            r_reg         <= r_next;
            neg_reg       <= neg_next;
            lower_reg     <= lower_next;
            chunk_reg     <= chunk_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // digit store: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[store_waddr] <= rem_reg;
        if (go && ctl.act == ACT_READ)
            rd_reg <= store_mem[store_raddr];
    end

    assign chars.valid      = out_valid_reg;
    assign chars.ascii_char = out_char_reg;
    assign chars.last_char  = out_last_reg;

    `ITRA_ASSERT_ALWAYS(a_count_bound, count_reg <= CNTW'(VALUE_BITS), "digit count overflow")
    `ITRA_ASSERT_ALWAYS(a_radix_range, r_reg >= RADIX_MIN && r_reg <= RADIX_MAX, "radix out of range")
    `ITRA_ASSERT_ALWAYS(a_rem_bound, RADIX_W'(rem_reg) < r_reg, "remainder not below radix")
    `ITRA_ASSERT_NEXT(a_start_div, number.valid && number.ready, step_reg == STEP_DIV && count_reg == '0, "transaction did not start division")
    `ITRA_ASSERT_ALWAYS(a_last_is_digit, !(chars.valid && chars.last_char && chars.ascii_char == ASCII_MINUS), "sign marked as last character")

endmodule

// ===== tb/sv/integer_to_radix_ascii_tb.sv =====
// testbench for the integer to radix ascii converter, checks every character
`timescale 1ns / 1ps

module integer_to_radix_ascii_tb;
    import itra_pkg::*;

    // one number with its conversion options
    typedef struct {
        logic [VALUE_W-1:0] value_bits;
        logic [RADIX_W-1:0] radix;
        logic               unsigned_mode;
        logic               lower_case;
    } number_req_t;

    // one character as it should leave the block
    typedef struct {
        logic [CHAR_W-1:0] ascii_char;
        logic              last_char;
    } char_rsp_t;

    localparam int RANDOM_NUMBERS = 350;
    localparam int CALM_TAIL      = 30;        // last numbers are sent with no idling
    localparam int DRAIN_CYCLES   = 300;       // wait after the drain, long enough for one full 33-character conversion
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int REPORT_MAX     = 10;

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2d;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    itra_num_if  number ();
    itra_char_if chars ();

    integer_to_radix_ascii u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number.sink),
        .chars  (chars.source)
    );

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    number_req_t pending_numbers[$];   // numbers not yet offered
    number_req_t number_on_bus;        // number currently driven on the input channel
    char_rsp_t   expected_chars[$];    // characters predicted, oldest first

    bit number_taken = 1'b0;           // set at the edge that accepted number_on_bus
    bit src_idle_en  = 1'b0;
    bit snk_idle_en  = 1'b0;
    int src_gap      = 0;
    int snk_stall    = 0;
    int error_count  = 0;
    int cycle_count  = 0;

    // ------------------------------------------------------------------
    // prediction: saturate the radix, strip the sign, divide down to the
    // digits and spell them most significant first
    // ------------------------------------------------------------------
    function automatic void spell_number(input number_req_t req);
        logic [VALUE_W-1:0] magnitude;
        logic [DIGIT_W-1:0] digits[$];
        int                 base;
        bit                 negative;
        string              alphabet;
        char_rsp_t          rsp;

        if (req.radix < 2)
            base = 2;
        else if (req.radix > 16)
            base = 16;
        else
            base = int'(req.radix);

        alphabet = req.lower_case ? "0123456789abcdef" : "0123456789ABCDEF";

        // two's complement negate wraps the most negative value onto its magnitude
        negative  = !req.unsigned_mode && req.value_bits[VALUE_W-1];
        magnitude = negative ? (~req.value_bits + 1'b1) : req.value_bits;

        // zero still yields one digit
        do
        begin
            digits.push_front(DIGIT_W'(magnitude % base));
            magnitude = magnitude / base;
        end
        while (magnitude != 0);

        if (negative)
        begin
            rsp.ascii_char = MINUS_CHAR;
            rsp.last_char  = 1'b0;
            expected_chars.push_back(rsp);
        end
        foreach (digits[i])
        begin
            rsp.ascii_char = alphabet[digits[i]];
            rsp.last_char  = (i == digits.size() - 1);
            expected_chars.push_back(rsp);
        end
    endfunction

    function automatic void queue_number(input logic [VALUE_W-1:0] value_bits,
                                         input int radix, input bit unsigned_mode,
                                         input bit lower_case);
        number_req_t req;
        req.value_bits    = value_bits;
        req.radix         = RADIX_W'(radix);
        req.unsigned_mode = unsigned_mode;
        req.lower_case    = lower_case;
        pending_numbers.push_back(req);
    endfunction

    // random values weighted toward the interesting corners
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4:          return $urandom_range(0, 20);
            5:          return 32'h8000_0000 + $urandom_range(0, 3);
            6:          return 32'hffff_ffff - $urandom_range(0, 3);
            7:          return 32'd1 << $urandom_range(0, VALUE_W - 1);
            8:          return $urandom >> $urandom_range(0, VALUE_W - 1);
            default:    return '0;
        endcase
    endfunction

    function automatic int pick_radix();
        // mostly legal bases, a few out of range to exercise saturation
        if ($urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1) : $urandom_range(17, 31);
        return $urandom_range(2, 16);
    endfunction

    // ------------------------------------------------------------------
    // input side: driver changes the channel on the falling edge only
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_numbers
        if (!rst_n)
        begin
            number.valid <= 1'b0;
        end
        else if (!number.valid || number_taken)
        begin
            number_taken = 1'b0;
            if (src_gap > 0)
            begin
                src_gap--;
                number.valid <= 1'b0;
            end
            else if (src_idle_en && $urandom_range(0, 4) == 0)
            begin
                // idle burst of random length, this one included
                src_gap = $urandom_range(0, 5);
                number.valid <= 1'b0;
            end
            else if (pending_numbers.size() > 0)
            begin
                number_on_bus        = pending_numbers.pop_front();
                number.value_bits    <= number_on_bus.value_bits;
                number.radix         <= number_on_bus.radix;
                number.unsigned_mode <= number_on_bus.unsigned_mode;
                number.lower_case    <= number_on_bus.lower_case;
                number.valid         <= 1'b1;
            end
            else
            begin
                number.valid <= 1'b0;
            end
        end
    end

    // prediction happens at the edge that accepts the number
    always @(posedge clk)
    begin : accept_numbers
        if (rst_n && number.valid && number.ready)
        begin
            spell_number(number_on_bus);
            number_taken = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // output side: random backpressure on the character channel
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_char_ready
        if (!rst_n)
        begin
            chars.ready <= 1'b0;
        end
        else if (snk_stall > 0)
        begin
            snk_stall--;
            chars.ready <= 1'b0;
        end
        else if (snk_idle_en && $urandom_range(0, 5) == 0)
        begin
            snk_stall = $urandom_range(0, 5);
            chars.ready <= 1'b0;
        end
        else
        begin
            chars.ready <= 1'b1;
        end
    end

    // monitor: each character transaction against the oldest prediction
    always @(posedge clk)
    begin : check_chars
        char_rsp_t want;
        if (rst_n && chars.valid && chars.ready)
        begin
            if (expected_chars.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("%0t: unexpected character 0x%02h last=%0b", $time,
                             chars.ascii_char, chars.last_char);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (chars.ascii_char !== want.ascii_char ||
                    chars.last_char !== want.last_char)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("%0t: mismatch, expected 0x%02h last=%0b, got 0x%02h last=%0b",
                                 $time, want.ascii_char, want.last_char,
                                 chars.ascii_char, chars.last_char);
                end
            end
        end
    end

    // idling switches on and off in stretches, and stops for the tail of the run
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count % 64 == 0)
        begin
            src_idle_en = (pending_numbers.size() > CALM_TAIL) && ($urandom_range(0, 2) != 0);
            snk_idle_en = (pending_numbers.size() > CALM_TAIL) && ($urandom_range(0, 2) != 0);
        end
        if (pending_numbers.size() <= CALM_TAIL)
        begin
            src_idle_en = 1'b0;
            snk_idle_en = 1'b0;
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        number.valid         = 1'b0;
        number.value_bits    = '0;
        number.radix         = '0;
        number.unsigned_mode = 1'b0;
        number.lower_case    = 1'b0;
        chars.ready          = 1'b0;

        // directed: zero, extremes, sign handling, both alphabets, radix saturation
        queue_number(32'd0,          10, 1'b0, 1'b0);
        queue_number(32'd0,           2, 1'b1, 1'b0);
        queue_number(32'd0,          16, 1'b0, 1'b1);
        queue_number(32'd1,           2, 1'b0, 1'b0);
        queue_number(32'h8000_0000,   2, 1'b0, 1'b0);   // longest string, sign plus 32 digits
        queue_number(32'h8000_0000,   2, 1'b1, 1'b0);
        queue_number(32'h8000_0000,  10, 1'b0, 1'b1);
        queue_number(32'hffff_ffff,   2, 1'b1, 1'b0);
        queue_number(32'hffff_ffff,  16, 1'b0, 1'b0);   // minus one
        queue_number(32'hffff_ffff,  16, 1'b1, 1'b0);
        queue_number(32'hffff_ffff,  16, 1'b1, 1'b1);
        queue_number(32'h7fff_ffff,  10, 1'b0, 1'b0);
        queue_number(32'h7fff_ffff,   3, 1'b1, 1'b1);
        queue_number(32'habcd_ef01,  16, 1'b1, 1'b0);
        queue_number(32'habcd_ef01,  16, 1'b1, 1'b1);
        queue_number(32'habcd_ef01,  16, 1'b0, 1'b1);
        queue_number(32'd255,         0, 1'b1, 1'b0);   // base below two
        queue_number(32'd255,         1, 1'b0, 1'b0);
        queue_number(32'd255,        17, 1'b1, 1'b1);   // base above sixteen
        queue_number(32'd255,        31, 1'b0, 1'b0);
        queue_number(32'hdead_beef,  15, 1'b1, 1'b0);
        queue_number(32'hffff_ff85,   7, 1'b0, 1'b1);
        queue_number(32'd12345,      11, 1'b0, 1'b0);

        for (int n = 0; n < RANDOM_NUMBERS; n++)
            queue_number(pick_value(), pick_radix(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain: everything offered, accepted and answered
        while (pending_numbers.size() != 0 || number.valid || expected_chars.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_chars.size() != 0)
            error_count++;

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
